@@ design/sngh_pkg.sv @@
// ----------------------------------------------------------------------------
// sngh_pkg
// Shared types, constants and helpers of the subword n-gram hasher.
// ----------------------------------------------------------------------------
package sngh_pkg;

  localparam logic [31:0] FNV_BASIS  = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;
  localparam logic [7:0]  MARK_BEGIN = 8'h3C;
  localparam logic [7:0]  MARK_END   = 8'h3E;

  localparam logic [2:0]  MIN_NGRAM_RST    = 3'd3;
  localparam logic [2:0]  MAX_NGRAM_RST    = 3'd6;
  localparam logic [23:0] BUCKET_COUNT_RST = 24'd2000000;

  // configuration register indexes
  localparam logic [1:0] CFG_MIN_NGRAM    = 2'd0;
  localparam logic [1:0] CFG_MAX_NGRAM    = 2'd1;
  localparam logic [1:0] CFG_BUCKET_COUNT = 2'd2;

  // byte source for one hash step
  typedef enum logic [1:0] {
    SRC_MEM   = 2'b00,
    SRC_BEGIN = 2'b01,
    SRC_END   = 2'b10
  } src_sel_t;

  // request to the modulo unit
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [23:0] modulus;
  } div_req_t;

  // number of continuation bytes a UTF-8 lead byte claims
  function automatic logic [1:0] lead_extra(input logic [7:0] b);
    logic [1:0] r;
    begin
      r = 2'd0;
      if ((b & 8'hE0) == 8'hC0) r = 2'd1;
      else if ((b & 8'hF0) == 8'hE0) r = 2'd2;
      else if ((b & 8'hF8) == 8'hF0) r = 2'd3;
      lead_extra = r;
    end
  endfunction

  function automatic logic [2:0] clamp_n(input logic [2:0] v);
    logic [2:0] r;
    begin
      r = v;
      if (v < 3'd3) r = 3'd3;
      else if (v > 3'd6) r = 3'd6;
      clamp_n = r;
    end
  endfunction

endpackage

@@ design/sngh_word_mem.sv @@
// ----------------------------------------------------------------------------
// sngh_word_mem
// Byte store of the current word, one write and one registered read port.
// ----------------------------------------------------------------------------
module sngh_word_mem #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);
  logic [7:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ design/sngh_offs_mem.sv @@
// ----------------------------------------------------------------------------
// sngh_offs_mem
// Character start offsets of the framed word, two registered read ports.
// ----------------------------------------------------------------------------
module sngh_offs_mem #(
  parameter int DEPTH = 19,
  parameter int DW    = 7
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [DW-1:0]            rdata_a,
  output logic [DW-1:0]            rdata_b
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

@@ design/sngh_divider.sv @@
// ----------------------------------------------------------------------------
// sngh_divider
// Restoring modulo unit: 32-bit hash mod 24-bit bucket count, one bit a cycle.
// ----------------------------------------------------------------------------
module sngh_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  sngh_pkg::div_req_t  req,
  output logic                done,
  output logic [23:0]         remainder
);
  import sngh_pkg::*;

  logic [31:0] quo_r, quo_nxt;
  logic [24:0] rem_r, rem_nxt;
  logic [23:0] mod_r, mod_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [24:0] shifted;

  assign shifted = {rem_r[23:0], quo_r[31]};

  // shift in one dividend bit, subtract when it fits
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    mod_nxt  = mod_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      mod_nxt  = (req.modulus == 24'd0) ? 24'd1 : req.modulus;
      cnt_nxt  = 6'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[30:0], 1'b0};
      rem_nxt = (shifted >= {1'b0, mod_r}) ? shifted - {1'b0, mod_r} : shifted;
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    mod_r <= mod_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r[23:0];
endmodule

@@ design/subword_ngram_hasher_top.sv @@
// ----------------------------------------------------------------------------
// subword_ngram_hasher_top
// Character n-gram hasher: stores a word, emits FNV-1a bucket ids of its grams.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry one word byte each; in_last_byte marks the end of the
//   word. Non-final bytes take one cycle each. After the final byte in_stall
//   stays high until the last result of the word is in the output register.
//   Each result beat carries one bucket id with its gram length and flags;
//   out_last_result marks the final id of the word. A word that yields no id
//   produces no result beat and the block returns to idle.
//   Per result: an offset lookup (none for the whole word), then for each
//   hashed byte a word store read and one FNV multiply, then the start of
//   the modulo, the wait on the bit-serial modulo unit and the load of the
//   output register. Word end adds setup before the first result.
//   The output register lets the next gram be computed while a result waits;
//   a stalled receiver holds the result and the sequencer waits at loading.
//   Reset (synchronous, active low) empties the word and restores the
//   registers to min_ngram 3, max_ngram 6, bucket_count 2000000. Configuration
//   must be written only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module subword_ngram_hasher_top #(
  parameter int MAX_WORD_BYTES = 64,
  parameter int MAX_WORD_CHARS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_word_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] out_subword_id,
  output logic [4:0]  out_gram_chars,
  output logic        out_whole_word,
  output logic        out_word_truncated,
  output logic        out_last_result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);
  import sngh_pkg::*;

  localparam int ADDR_W = $clog2(MAX_WORD_BYTES);
  localparam int BC_W   = $clog2(MAX_WORD_BYTES + 1);
  localparam int OFF_W  = $clog2(MAX_WORD_BYTES + 3);
  localparam int K_W    = $clog2(MAX_WORD_CHARS + 1);
  localparam int ODEPTH = MAX_WORD_CHARS + 3;
  localparam int OIDX_W = $clog2(ODEPTH);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_FIN0  = 11'b00000000010,
    ST_FIN1  = 11'b00000000100,
    ST_FIN2  = 11'b00000001000,
    ST_PLAN  = 11'b00000010000,
    ST_OREAD = 11'b00000100000,
    ST_OWAIT = 11'b00001000000,
    ST_HADDR = 11'b00010000000,
    ST_HMUL  = 11'b00100000000,
    ST_MOD   = 11'b01000000000,
    ST_EMIT  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [2:0]  min_ngram_r, max_ngram_r;
  logic [23:0] bucket_count_r;

  // word capture state
  logic [BC_W-1:0]   bc_r, bc_nxt;
  logic [K_W-1:0]    k_r, k_nxt;
  logic [OFF_W-1:0]  pos_r, pos_nxt;
  logic [1:0]        rem_r, rem_nxt;
  logic              frozen_r, frozen_nxt;
  logic              ovf_r, ovf_nxt;

  // gram iteration and hashing
  logic              whole_r, whole_nxt;
  logic [2:0]        n_r, n_nxt;
  logic [OIDX_W-1:0] s_r, s_nxt;
  logic [OFF_W-1:0]  i_r, i_nxt;
  logic [OFF_W-1:0]  to_r, to_nxt;
  logic [31:0]       h_r, h_nxt;
  src_sel_t          src_r, src_nxt;

  // output register
  logic        ov_r, ov_nxt;
  logic [23:0] oid_r, oid_nxt;
  logic [4:0]  ochars_r, ochars_nxt;
  logic        owhole_r, owhole_nxt;
  logic        otrunc_r, otrunc_nxt;
  logic        olast_r, olast_nxt;

  // memory ports
  logic              wm_we;
  logic [ADDR_W-1:0] wm_raddr;
  logic [7:0]        wm_rdata;
  logic              om_we;
  logic [OIDX_W-1:0] om_waddr, om_raddr_a, om_raddr_b;
  logic [OFF_W-1:0]  om_wdata, om_rdata_a, om_rdata_b;

  div_req_t    dreq;
  logic        ddone;
  logic [23:0] drem;

  logic              in_acc, out_free;
  logic [2:0]        lo, hi;
  logic [OIDX_W-1:0] len, n_ext, lo_ext, hi_ext;
  logic              has_next;
  logic [7:0]        hbyte;
  logic [31:0]       hx;
  logic              stored;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !ov_r || !out_stall;
  assign lo       = clamp_n(min_ngram_r);
  assign hi       = clamp_n(max_ngram_r);
  assign len      = OIDX_W'(k_r) + OIDX_W'(2);
  assign n_ext    = OIDX_W'(n_r);
  assign lo_ext   = OIDX_W'(lo);
  assign hi_ext   = OIDX_W'(hi);
  assign stored   = (bc_r < BC_W'(MAX_WORD_BYTES));

  // another gram follows the current one
  always_comb begin
    if (whole_r) begin
      has_next = (lo <= hi) && (lo_ext <= len);
    end else begin
      has_next = ((s_r + n_ext + OIDX_W'(1)) <= len) ||
                 ((n_r < hi) && ((n_ext + OIDX_W'(1)) <= len));
    end
  end

  // select and hash one framed byte
  always_comb begin
    case (src_r)
      SRC_BEGIN: hbyte = MARK_BEGIN;
      SRC_END:   hbyte = MARK_END;
      default:   hbyte = wm_rdata;
    endcase
    hx = (h_r ^ {{24{hbyte[7]}}, hbyte}) * FNV_PRIME;
  end

  assign wm_we    = in_acc && stored;
  assign wm_raddr = ADDR_W'(i_r - OFF_W'(1));

  always_comb begin
    state_nxt  = state_r;
    bc_nxt     = bc_r;
    k_nxt      = k_r;
    pos_nxt    = pos_r;
    rem_nxt    = rem_r;
    frozen_nxt = frozen_r;
    ovf_nxt    = ovf_r;
    whole_nxt  = whole_r;
    n_nxt      = n_r;
    s_nxt      = s_r;
    i_nxt      = i_r;
    to_nxt     = to_r;
    h_nxt      = h_r;
    src_nxt    = src_r;
    ov_nxt     = ov_r && out_stall;
    oid_nxt    = oid_r;
    ochars_nxt = ochars_r;
    owhole_nxt = owhole_r;
    otrunc_nxt = otrunc_r;
    olast_nxt  = olast_r;
    om_we      = 1'b0;
    om_waddr   = '0;
    om_wdata   = '0;
    om_raddr_a = s_r;
    om_raddr_b = s_r + n_ext;
    dreq.start    = 1'b0;
    dreq.dividend = h_r;
    dreq.modulus  = bucket_count_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          // store the byte and track character boundaries
          if (stored) begin
            bc_nxt = bc_r + BC_W'(1);
            if (!frozen_r) begin
              if (rem_r == 2'd0) begin
                if (k_r == K_W'(MAX_WORD_CHARS)) begin
                  frozen_nxt = 1'b1;
                  ovf_nxt    = 1'b1;
                end else begin
                  om_we    = 1'b1;
                  om_waddr = OIDX_W'(k_r) + OIDX_W'(1);
                  om_wdata = OFF_W'(bc_r) + OFF_W'(1);
                  k_nxt    = k_r + K_W'(1);
                  rem_nxt  = lead_extra(in_word_byte);
                  pos_nxt  = OFF_W'(bc_r) + OFF_W'(1);
                end
              end else begin
                rem_nxt = rem_r - 2'd1;
                pos_nxt = OFF_W'(bc_r) + OFF_W'(1);
              end
            end
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_byte) begin
            state_nxt = ST_FIN0;
          end
        end
      end
      // write closing offsets and the fixed first one
      ST_FIN0: begin
        om_we     = 1'b1;
        om_waddr  = OIDX_W'(k_r) + OIDX_W'(1);
        om_wdata  = pos_r + OFF_W'(1);
        state_nxt = ST_FIN1;
      end
      ST_FIN1: begin
        om_we     = 1'b1;
        om_waddr  = OIDX_W'(k_r) + OIDX_W'(2);
        om_wdata  = pos_r + OFF_W'(2);
        state_nxt = ST_FIN2;
      end
      ST_FIN2: begin
        om_we     = 1'b1;
        om_waddr  = '0;
        om_wdata  = '0;
        state_nxt = ST_PLAN;
      end
      // choose the whole word or the first gram, or return to idle if none
      ST_PLAN: begin
        if (len > hi_ext) begin
          whole_nxt = 1'b1;
          i_nxt     = '0;
          to_nxt    = pos_r + OFF_W'(2);
          h_nxt     = FNV_BASIS;
          state_nxt = ST_HADDR;
        end else if ((lo <= hi) && (lo_ext <= len)) begin
          whole_nxt = 1'b0;
          n_nxt     = lo;
          s_nxt     = '0;
          state_nxt = ST_OREAD;
        end else begin
          bc_nxt     = '0;
          k_nxt      = '0;
          pos_nxt    = '0;
          rem_nxt    = '0;
          frozen_nxt = 1'b0;
          ovf_nxt    = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      ST_OREAD: begin
        state_nxt = ST_OWAIT;
      end
      ST_OWAIT: begin
        i_nxt     = om_rdata_a;
        to_nxt    = om_rdata_b;
        h_nxt     = FNV_BASIS;
        state_nxt = ST_HADDR;
      end
      // fetch the next framed byte or start the modulo
      ST_HADDR: begin
        if (i_r == to_r) begin
          dreq.start = 1'b1;
          state_nxt  = ST_MOD;
        end else begin
          if (i_r == '0) src_nxt = SRC_BEGIN;
          else if (i_r == pos_r + OFF_W'(1)) src_nxt = SRC_END;
          else src_nxt = SRC_MEM;
          state_nxt = ST_HMUL;
        end
      end
      ST_HMUL: begin
        h_nxt     = hx;
        i_nxt     = i_r + OFF_W'(1);
        state_nxt = ST_HADDR;
      end
      ST_MOD: begin
        if (ddone) begin
          state_nxt = ST_EMIT;
        end
      end
      // load the output register, then advance the gram or end the word
      ST_EMIT: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          oid_nxt    = drem;
          ochars_nxt = whole_r ? 5'(len) : 5'(n_r);
          owhole_nxt = whole_r;
          otrunc_nxt = ovf_r;
          olast_nxt  = !has_next;
          if (has_next) begin
            state_nxt = ST_OREAD;
            if (whole_r) begin
              whole_nxt = 1'b0;
              n_nxt     = lo;
              s_nxt     = '0;
            end else if ((s_r + n_ext + OIDX_W'(1)) <= len) begin
              s_nxt = s_r + OIDX_W'(1);
            end else begin
              n_nxt = n_r + 3'd1;
              s_nxt = '0;
            end
          end else begin
            bc_nxt     = '0;
            k_nxt      = '0;
            pos_nxt    = '0;
            rem_nxt    = '0;
            frozen_nxt = 1'b0;
            ovf_nxt    = 1'b0;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_ngram_r    <= MIN_NGRAM_RST;
      max_ngram_r    <= MAX_NGRAM_RST;
      bucket_count_r <= BUCKET_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_NGRAM:    min_ngram_r    <= cfg_wdata[2:0];
        CFG_MAX_NGRAM:    max_ngram_r    <= cfg_wdata[2:0];
        CFG_BUCKET_COUNT: bucket_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      bc_r     <= '0;
      k_r      <= '0;
      pos_r    <= '0;
      rem_r    <= '0;
      frozen_r <= 1'b0;
      ovf_r    <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      bc_r     <= bc_nxt;
      k_r      <= k_nxt;
      pos_r    <= pos_nxt;
      rem_r    <= rem_nxt;
      frozen_r <= frozen_nxt;
      ovf_r    <= ovf_nxt;
      ov_r     <= ov_nxt;
    end
    whole_r  <= whole_nxt;
    n_r      <= n_nxt;
    s_r      <= s_nxt;
    i_r      <= i_nxt;
    to_r     <= to_nxt;
    h_r      <= h_nxt;
    src_r    <= src_nxt;
    oid_r    <= oid_nxt;
    ochars_r <= ochars_nxt;
    owhole_r <= owhole_nxt;
    otrunc_r <= otrunc_nxt;
    olast_r  <= olast_nxt;
  end

  sngh_word_mem #(.DEPTH(MAX_WORD_BYTES)) u_word_mem (
    .clk   (clk),
    .we    (wm_we),
    .waddr (bc_r[ADDR_W-1:0]),
    .wdata (in_word_byte),
    .raddr (wm_raddr),
    .rdata (wm_rdata)
  );

  sngh_offs_mem #(.DEPTH(ODEPTH), .DW(OFF_W)) u_offs_mem (
    .clk     (clk),
    .we      (om_we),
    .waddr   (om_waddr),
    .wdata   (om_wdata),
    .raddr_a (om_raddr_a),
    .raddr_b (om_raddr_b),
    .rdata_a (om_rdata_a),
    .rdata_b (om_rdata_b)
  );

  sngh_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (dreq),
    .done      (ddone),
    .remainder (drem)
  );

  assign out_valid          = ov_r;
  assign out_subword_id     = oid_r;
  assign out_gram_chars     = ochars_r;
  assign out_whole_word     = owhole_r;
  assign out_word_truncated = otrunc_r;
  assign out_last_result    = olast_r;
endmodule

@@ design/sngh_checker.sv @@
// ----------------------------------------------------------------------------
// sngh_checker
// Port-level checks of the subword n-gram hasher, bound to the top level.
// ----------------------------------------------------------------------------
module sngh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [23:0] out_subword_id,
  input logic [4:0]  out_gram_chars,
  input logic        out_whole_word,
  input logic        out_word_truncated,
  input logic        out_last_result
);
  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_subword_id) &&
    $stable(out_last_result) && $stable(out_gram_chars) &&
    $stable(out_whole_word) && $stable(out_word_truncated))
    else $error("stalled result beat changed");

  // no result right after reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat after reset");

  // a whole-word beat has at least four characters
  a_whole_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_whole_word |-> out_gram_chars >= 5'd4)
    else $error("whole-word beat too short");

  // a gram beat has a length in the gram range
  a_gram_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_whole_word |-> out_gram_chars >= 5'd3 && out_gram_chars <= 5'd6)
    else $error("gram length out of range");

  // the block takes no byte while results are still due
  a_no_in_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |-> in_stall)
    else $error("input taken during emission");
endmodule

bind subword_ngram_hasher_top sngh_checker u_sngh_checker (.*);
